@@ hw/rtl/sps_pkg.sv @@
package sps_pkg;

	localparam int PAGE_BYTES       = 4096;
	localparam int PAGE_AW          = 12;
	localparam int MAX_RECORDS      = 256;
	localparam int SLOT_AW          = 8;
	localparam int HEADER_BYTES     = 12;
	localparam int SLOT_ENTRY_BYTES = 4;

	// command codes
	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_UPDATE = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_SLOT  = 3'd1;
	localparam logic [2:0] ST_NO_SPACE = 3'd2;
	localparam logic [2:0] ST_DIR_FULL = 3'd3;
	localparam logic [2:0] ST_BAD_IDX  = 3'd4;

	// one slot directory entry
	typedef struct packed {
		logic [12:0]        len;
		logic [PAGE_AW-1:0] pos;
	} dir_ent_t;

	// directory write request
	typedef struct packed {
		logic               en;
		logic [SLOT_AW-1:0] addr;
		dir_ent_t           ent;
	} dir_wr_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_DIR,
		S_RD_BYTE,
		S_SCAN,
		S_INS_CHK,
		S_CMP_START,
		S_CMP_DIR,
		S_CMP_COPY,
		S_UPD_FIN,
		S_PLACE,
		S_FINISH
	} state_t;

endpackage

@@ hw/rtl/sps_ram.sv @@
module sps_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/sps_slot_dir.sv @@
module sps_slot_dir (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clr,
	input  sps_pkg::dir_wr_t            wr,
	input  logic [sps_pkg::SLOT_AW-1:0] raddr,
	output sps_pkg::dir_ent_t           rdata
);
	import sps_pkg::*;

	dir_ent_t               mem [MAX_RECORDS];
	logic [MAX_RECORDS-1:0] valid_q;
	dir_ent_t               rd_q;
	logic                   rd_valid_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.ent;
		end
		rd_q <= mem[raddr];
	end

	// per-entry valid bits; a never-written entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[raddr];
			if (clr) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

@@ hw/rtl/slotted_page_record_store.sv @@
// Record bytes that do not end a record are taken one per cycle, with no result.
// Clear goes to S_FINISH; remove passes S_RD_DIR, read also S_RD_BYTE if the byte exists.
// Insert scans the directory one entry a cycle, then copies the record one byte a cycle;
// compaction copies live records. The next item is taken the cycle after the result
// register loads, later while the output stalls. Reset is asynchronous and empties the
// directory and staging; page bytes are only read after a record has written them.
module slotted_page_record_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// slot_index[7:0], byte_index[19:8], data_in[27:20], zero fill
	input  logic [31:0] s_axis_tdata,
	// cmd[2:0]
	input  logic [2:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// slot_out[7:0], data_out[15:8], record_length[28:16], free_bytes[41:29],
	// used_slots[50:42], zero fill
	output logic [55:0] m_axis_tdata,
	// status[2:0]
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast
);
	import sps_pkg::*;

	state_t state_q, state_d;

	// input unpacking
	logic               acc;
	logic [2:0]         in_cmd;
	logic [SLOT_AW-1:0] in_slot;
	logic [11:0]        in_bidx;
	logic [7:0]         in_data;
	assign acc     = s_axis_tvalid & s_axis_tready;
	assign in_cmd  = s_axis_tuser;
	assign in_slot = s_axis_tdata[7:0];
	assign in_bidx = s_axis_tdata[19:8];
	assign in_data = s_axis_tdata[27:20];

	// architectural state
	logic [12:0] count_q, free_end_q, live_q;
	logic [8:0]  total_q;
	logic        bank_q;

	// item context
	logic [2:0]         cmd_q;
	logic [SLOT_AW-1:0] slot_q, target_q;
	logic [11:0]        bidx_q;
	logic [12:0]        len_q, end_q;
	logic [8:0]         idx_q;
	logic               reuse_q, cmp_done_q;

	// copy engine
	logic [PAGE_AW-1:0] cp_src_q, cp_dst_q, cp_wa_s1;
	logic [12:0]        cp_len_q, cnt_q;
	logic               cp_v_s1, cp_place_s1;

	// result registers
	logic [2:0]  res_status_q, m_status_q;
	logic [7:0]  res_slot_q, res_data_q, m_slot_q, m_data_q;
	logic [12:0] res_rlen_q, m_rlen_q, m_free_q;
	logic        res_last_q, m_last_q, m_valid_q;
	logic [8:0]  m_used_q;

	// memories
	dir_ent_t           d;
	dir_wr_t            dir_wr;
	logic               dir_clr;
	logic [SLOT_AW-1:0] dir_raddr;
	logic [PAGE_AW-1:0] pg_raddr, stg_raddr;
	logic [7:0]         b0_rd, b1_rd, stg_rd, act_rd, pg_wdata;
	logic               b0_we, b1_we, stg_we, dst_bank;

	sps_slot_dir u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (dir_clr),
		.wr     (dir_wr),
		.raddr  (dir_raddr),
		.rdata  (d)
	);

	sps_ram #(.DEPTH(PAGE_BYTES), .WIDTH(8)) u_bank0 (
		.clk(clk), .we(b0_we), .waddr(cp_wa_s1), .wdata(pg_wdata),
		.raddr(pg_raddr), .rdata(b0_rd)
	);

	sps_ram #(.DEPTH(PAGE_BYTES), .WIDTH(8)) u_bank1 (
		.clk(clk), .we(b1_we), .waddr(cp_wa_s1), .wdata(pg_wdata),
		.raddr(pg_raddr), .rdata(b1_rd)
	);

	sps_ram #(.DEPTH(PAGE_BYTES), .WIDTH(8)) u_stage (
		.clk(clk), .we(stg_we), .waddr(count_q[PAGE_AW-1:0]), .wdata(in_data),
		.raddr(stg_raddr), .rdata(stg_rd)
	);

	// shared decisions
	logic [12:0] new_len, start, free, place_pos, cmp_end;
	logic [13:0] needed, upd_used;
	logic        miss, scan_end, cmp_skip, copy_end, out_free, cmd_byte;

	always_comb begin
		cmd_byte  = (in_cmd == CMD_INSERT) || (in_cmd == CMD_UPDATE);
		new_len   = count_q[12] ? 13'(PAGE_BYTES + 1) : count_q + 13'd1;
		start     = 13'(HEADER_BYTES) + 13'(total_q) * 13'(SLOT_ENTRY_BYTES);
		free      = (free_end_q > start) ? free_end_q - start : 13'd0;
		miss      = ({1'b0, slot_q} >= total_q) || (d.len == 13'd0);
		needed    = {1'b0, len_q} + (reuse_q ? 14'd0 : 14'(SLOT_ENTRY_BYTES));
		upd_used  = 14'(start) + 14'(live_q) - 14'(d.len);
		place_pos = free_end_q - len_q;
		scan_end  = idx_q >= total_q;
		cmp_end   = end_q - d.len;
		cmp_skip  = (d.len == 13'd0) || (d.len > end_q) ||
			({2'b0, d.pos} > 14'(PAGE_BYTES) - {1'b0, d.len});
		copy_end  = cnt_q == cp_len_q;
		out_free  = !m_valid_q || m_axis_tready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (in_cmd)
						CMD_INSERT: state_d = s_axis_tlast ? S_SCAN : S_IDLE;
						CMD_UPDATE: state_d = s_axis_tlast ? S_RD_DIR : S_IDLE;
						CMD_REMOVE, CMD_READ: state_d = S_RD_DIR;
						CMD_CLEAR: state_d = S_FINISH;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_RD_DIR: begin
				priority if (cmd_q == CMD_READ) begin
					state_d = (miss || {1'b0, bidx_q} >= d.len) ? S_FINISH : S_RD_BYTE;
				end else if (cmd_q == CMD_UPDATE && !miss) begin
					priority if (len_q == d.len || {1'b0, free} >= {1'b0, len_q}) begin
						state_d = S_PLACE;
					end else if (upd_used > 14'(PAGE_BYTES) ||
						14'(PAGE_BYTES) - upd_used < {1'b0, len_q}) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_CMP_START;
					end
				end else begin
					state_d = S_FINISH;
				end
			end
			S_RD_BYTE: state_d = S_FINISH;
			S_SCAN: begin
				if (scan_end || d.len == 13'd0) begin
					state_d = S_INS_CHK;
				end
			end
			S_INS_CHK: begin
				priority if (!reuse_q && total_q >= 9'(MAX_RECORDS)) begin
					state_d = S_FINISH;
				end else if ({1'b0, free} < needed) begin
					state_d = cmp_done_q ? S_FINISH : S_CMP_START;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_CMP_START: state_d = S_CMP_DIR;
			S_CMP_DIR: begin
				priority if (scan_end) begin
					state_d = (cmd_q == CMD_INSERT) ? S_INS_CHK : S_UPD_FIN;
				end else if (!cmp_skip) begin
					state_d = S_CMP_COPY;
				end
			end
			S_CMP_COPY: if (copy_end) state_d = S_CMP_DIR;
			S_UPD_FIN: state_d = S_PLACE;
			S_PLACE: if (copy_end) state_d = S_FINISH;
			S_FINISH: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		dir_raddr = '0;
		dir_wr    = '0;
		dir_clr   = acc && (in_cmd == CMD_CLEAR);
		pg_raddr  = cp_src_q + cnt_q[PAGE_AW-1:0];
		stg_raddr = cnt_q[PAGE_AW-1:0];
		stg_we    = acc && cmd_byte && !count_q[12];
		unique case (state_q)
			S_IDLE: dir_raddr = (in_cmd == CMD_INSERT) ? '0 : in_slot;
			S_RD_DIR: begin
				pg_raddr = d.pos + bidx_q;
				if (!miss && cmd_q == CMD_REMOVE) begin
					dir_wr.en   = 1'b1;
					dir_wr.addr = slot_q;
				end else if (!miss && cmd_q == CMD_UPDATE && len_q != d.len) begin
					dir_wr.addr = slot_q;
					if ({1'b0, free} >= {1'b0, len_q}) begin
						dir_wr.en  = 1'b1;
						dir_wr.ent = '{len: len_q, pos: place_pos[PAGE_AW-1:0]};
					end else if (!(upd_used > 14'(PAGE_BYTES) ||
						14'(PAGE_BYTES) - upd_used < {1'b0, len_q})) begin
						dir_wr.en  = 1'b1;
						dir_wr.ent = '{len: 13'd0, pos: d.pos};
					end
				end
			end
			S_SCAN, S_CMP_COPY: dir_raddr = 8'(idx_q + 9'd1);
			S_INS_CHK: begin
				if ((reuse_q || total_q < 9'(MAX_RECORDS)) && {1'b0, free} >= needed) begin
					dir_wr.en  = 1'b1;
					dir_wr.addr = target_q;
					dir_wr.ent = '{len: len_q, pos: place_pos[PAGE_AW-1:0]};
				end
			end
			S_CMP_DIR: begin
				dir_raddr = 8'(idx_q + 9'd1);
				if (!scan_end && !cmp_skip) begin
					dir_wr.en   = 1'b1;
					dir_wr.addr = idx_q[SLOT_AW-1:0];
					dir_wr.ent  = '{len: d.len, pos: cmp_end[PAGE_AW-1:0]};
				end
			end
			S_UPD_FIN: begin
				dir_wr.en   = 1'b1;
				dir_wr.addr = slot_q;
				dir_wr.ent  = '{len: len_q, pos: place_pos[PAGE_AW-1:0]};
			end
			default: dir_raddr = '0;
		endcase
	end

	// page bank write steering: compaction fills the idle bank
	assign act_rd   = bank_q ? b1_rd : b0_rd;
	assign dst_bank = cp_place_s1 ? bank_q : ~bank_q;
	assign pg_wdata = cp_place_s1 ? stg_rd : act_rd;
	assign b0_we    = cp_v_s1 && !dst_bank;
	assign b1_we    = cp_v_s1 && dst_bank;

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			free_end_q <= 13'(PAGE_BYTES);
			live_q     <= '0;
			total_q    <= '0;
			bank_q     <= 1'b0;
			m_valid_q  <= 1'b0;
			cp_v_s1    <= 1'b0;
		end else begin
			state_q     <= state_d;
			cp_v_s1     <= ((state_q == S_CMP_COPY) || (state_q == S_PLACE)) && !copy_end;
			cp_place_s1 <= (state_q == S_PLACE);
			if (state_q == S_FINISH && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						cmd_q        <= in_cmd;
						slot_q       <= in_slot;
						bidx_q       <= in_bidx;
						idx_q        <= '0;
						cmp_done_q   <= 1'b0;
						res_status_q <= ST_OK;
						res_slot_q   <= '0;
						res_data_q   <= '0;
						res_rlen_q   <= '0;
						res_last_q   <= 1'b0;
						if (cmd_byte) begin
							len_q   <= new_len;
							count_q <= s_axis_tlast ? 13'd0 : new_len;
						end else if (in_cmd == CMD_CLEAR) begin
							count_q    <= '0;
							total_q    <= '0;
							free_end_q <= 13'(PAGE_BYTES);
							live_q     <= '0;
						end
					end
				end
				S_RD_DIR: begin
					cnt_q    <= '0;
					cp_len_q <= len_q;
					if (miss) begin
						res_status_q <= ST_NO_SLOT;
					end else if (cmd_q == CMD_REMOVE) begin
						live_q <= live_q - d.len;
					end else if (cmd_q == CMD_READ) begin
						res_rlen_q <= d.len;
						if ({1'b0, bidx_q} >= d.len) begin
							res_status_q <= ST_BAD_IDX;
						end else begin
							res_last_q <= ({1'b0, bidx_q} + 13'd1) == d.len;
						end
					end else if (cmd_q == CMD_UPDATE) begin
						if (len_q == d.len) begin
							cp_dst_q <= d.pos;
						end else if ({1'b0, free} >= {1'b0, len_q}) begin
							cp_dst_q   <= place_pos[PAGE_AW-1:0];
							free_end_q <= place_pos;
							live_q     <= live_q + len_q - d.len;
						end else if (upd_used > 14'(PAGE_BYTES) ||
							14'(PAGE_BYTES) - upd_used < {1'b0, len_q}) begin
							res_status_q <= ST_NO_SPACE;
						end else begin
							live_q <= live_q - d.len;
						end
					end
				end
				S_RD_BYTE: res_data_q <= act_rd;
				S_SCAN: begin
					if (scan_end) begin
						reuse_q  <= 1'b0;
						target_q <= total_q[SLOT_AW-1:0];
					end else if (d.len == 13'd0) begin
						reuse_q  <= 1'b1;
						target_q <= idx_q[SLOT_AW-1:0];
					end else begin
						idx_q <= idx_q + 9'd1;
					end
				end
				S_INS_CHK: begin
					if (!reuse_q && total_q >= 9'(MAX_RECORDS)) begin
						res_status_q <= ST_DIR_FULL;
					end else if ({1'b0, free} < needed) begin
						if (cmp_done_q) res_status_q <= ST_NO_SPACE;
					end else begin
						if (!reuse_q) total_q <= total_q + 9'd1;
						free_end_q <= place_pos;
						live_q     <= live_q + len_q;
						res_slot_q <= target_q;
						cp_dst_q   <= place_pos[PAGE_AW-1:0];
						cnt_q      <= '0;
						cp_len_q   <= len_q;
					end
				end
				S_CMP_START: begin
					idx_q <= '0;
					end_q <= 13'(PAGE_BYTES);
				end
				S_CMP_DIR: begin
					if (scan_end) begin
						free_end_q <= end_q;
						bank_q     <= ~bank_q;
						cmp_done_q <= 1'b1;
					end else if (cmp_skip) begin
						idx_q <= idx_q + 9'd1;
					end else begin
						end_q    <= cmp_end;
						cp_src_q <= d.pos;
						cp_dst_q <= cmp_end[PAGE_AW-1:0];
						cp_len_q <= d.len;
						cnt_q    <= '0;
					end
				end
				S_CMP_COPY, S_PLACE: begin
					if (!copy_end) begin
						cnt_q    <= cnt_q + 13'd1;
						cp_wa_s1 <= cp_dst_q + cnt_q[PAGE_AW-1:0];
					end else if (state_q == S_CMP_COPY) begin
						idx_q <= idx_q + 9'd1;
					end
				end
				S_UPD_FIN: begin
					free_end_q <= place_pos;
					live_q     <= live_q + len_q;
					cp_dst_q   <= place_pos[PAGE_AW-1:0];
					cnt_q      <= '0;
					cp_len_q   <= len_q;
				end
				S_FINISH: begin
					if (out_free) begin
						m_status_q <= res_status_q;
						m_slot_q   <= res_slot_q;
						m_data_q   <= res_data_q;
						m_rlen_q   <= res_rlen_q;
						m_last_q   <= res_last_q;
						m_free_q   <= free;
						m_used_q   <= total_q;
					end
				end
				default: ;
			endcase
		end
	end

	// ports
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {5'd0, m_used_q, m_free_q, m_rlen_q, m_data_q, m_slot_q};

endmodule
